>>> rtl/lsf_pkg.sv
// Shared types, constants and helper functions for the least-squares line fit.
// No dependencies; every other file of the block uses it by scoped names.
`default_nettype none

package lsf_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_FIRST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_FINAL = 1'b1;

    localparam int XW    = 16;
    localparam int NW    = 17;
    localparam int SXW   = 33;
    localparam int SXXW  = 47;
    localparam int SXYW  = 48;
    localparam int W     = 208;
    localparam int MW    = 64;
    localparam int CW    = $clog2(W + 1);
    localparam int OW    = 48;
    localparam int CORRW = 18;

    typedef logic [W-1:0] word_t;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        FIT_OK     = 2'd0,
        FIT_SINGLE = 2'd1,
        FIT_XFLAT  = 2'd2,
        FIT_YFLAT  = 2'd3
    } status_t;

    typedef struct packed {
        logic [NW-1:0]          n;
        logic signed [SXW-1:0]  sx;
        logic signed [SXW-1:0]  sy;
        logic [SXXW-1:0]        sxx;
        logic [SXXW-1:0]        syy;
        logic signed [SXYW-1:0] sxy;
        logic                   single;
    } snap_t;

    typedef struct packed {
        logic  start;
        op_t   op;
        word_t a;
        word_t b;
    } arith_req_t;

    typedef struct packed {
        logic  busy;
        logic  done;
        word_t res;
    } arith_rsp_t;

    typedef struct packed {
        logic  neg;
        word_t mag;
    } smag_t;

    // a - b on sign/magnitude operands
    function automatic smag_t sdiff(word_t am, logic an, word_t bm, logic bn);
        logic signed [W:0] sa;
        logic signed [W:0] sb;
        logic signed [W:0] d;
        smag_t r;
        sa = an ? -$signed({1'b0, am}) : $signed({1'b0, am});
        sb = bn ? -$signed({1'b0, bm}) : $signed({1'b0, bm});
        d = sa - sb;
        r.neg = d[W];
        r.mag = d[W] ? W'(-d) : W'(d);
        return r;
    endfunction

    // saturate a quotient magnitude to signed 48 bits and apply the sign
    function automatic logic [OW-1:0] qsat(word_t q, logic neg);
        word_t lim;
        logic [OW-1:0] m;
        lim = neg ? word_t'(48'h8000_0000_0000) : word_t'(48'h7FFF_FFFF_FFFF);
        m = (q > lim) ? lim[OW-1:0] : q[OW-1:0];
        return neg ? -m : m;
    endfunction

    // s = floor(sqrt(4a/b)); round-half-up of sqrt(a/b), clamped
    function automatic word_t rsat(word_t s, word_t lim);
        word_t r;
        r = (s + word_t'(1)) >> 1;
        return (r > lim) ? lim : r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/least_squares_line_fit_top.sv
// Least-squares line fit: front end, snapshot queue and serial solver (lsf_pkg, lsf_* modules).
// Throughput: one sample pair per cycle; a pair is taken the cycle start is high and busy low.
// Solver steps: a full fit runs them all; with no y spread the correlation divide and root are
// skipped, and a single-point window or no x spread stops before the slope divide; a closed set
// may also wait for a set still solving. The serial unit runs one multiply, divide or root at a time.
// Busy only while two closed sets wait; async active-low reset: sums 0, bounds -1; no output stall.
`default_nettype none

module least_squares_line_fit_top #(
    parameter int MAX_SAMPLES = lsf_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [lsf_pkg::XW-1:0]     x_value,
    input  wire logic signed [lsf_pkg::XW-1:0]     y_value,
    input  wire logic                              is_last,
    input  wire logic                              cfg_we,
    input  wire logic [lsf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lsf_pkg::CFG_W-1:0]         cfg_data,
    output logic                                   done,
    output logic signed [lsf_pkg::OW-1:0]          slope_q16,
    output logic signed [lsf_pkg::OW-1:0]          intercept_q16,
    output logic signed [lsf_pkg::CORRW-1:0]       correlation_q16,
    output logic [lsf_pkg::OW-1:0]                 slope_dev_q16,
    output logic [lsf_pkg::OW-1:0]                 intercept_dev_q16,
    output logic [1:0]                             fit_status
);

    logic           take;
    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;
    lsf_pkg::snap_t snap_in;
    lsf_pkg::snap_t snap_out;

    assign busy = q_full;
    assign take = start && !q_full;

    lsf_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .x_value   (x_value),
        .y_value   (y_value),
        .is_last   (is_last),
        .push      (push),
        .snap      (snap_in)
    );

    lsf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (snap_in),
        .pop   (pop),
        .dout  (snap_out),
        .empty (q_empty),
        .full  (q_full)
    );

    lsf_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_empty           (q_empty),
        .q_data            (snap_out),
        .q_pop             (pop),
        .done              (done),
        .slope_q16         (slope_q16),
        .intercept_q16     (intercept_q16),
        .correlation_q16   (correlation_q16),
        .slope_dev_q16     (slope_dev_q16),
        .intercept_dev_q16 (intercept_dev_q16),
        .fit_status        (fit_status)
    );

endmodule

`default_nettype wire

>>> rtl/lsf_front.sv
// Front end: window registers, sample indexing and exact running sums.
// Depends on lsf_pkg; pushes one snapshot per closed data set.
`default_nettype none

module lsf_front #(
    parameter int MAX_SAMPLES = lsf_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [lsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lsf_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          take,
    input  wire logic signed [lsf_pkg::XW-1:0] x_value,
    input  wire logic signed [lsf_pkg::XW-1:0] y_value,
    input  wire logic                          is_last,
    output logic                               push,
    output lsf_pkg::snap_t                     snap
);

    localparam int IW   = $clog2(MAX_SAMPLES + 1);
    localparam int CMPW = IW + 14;

    logic signed [lsf_pkg::CFG_W-1:0]  win_first_reg;
    logic signed [lsf_pkg::CFG_W-1:0]  win_final_reg;
    logic [IW-1:0]                     idx_reg;
    logic [lsf_pkg::NW-1:0]            cnt_reg;
    logic signed [lsf_pkg::SXW-1:0]    sx_reg;
    logic signed [lsf_pkg::SXW-1:0]    sy_reg;
    logic [lsf_pkg::SXXW-1:0]          sxx_reg;
    logic [lsf_pkg::SXXW-1:0]          syy_reg;
    logic signed [lsf_pkg::SXYW-1:0]   sxy_reg;

    logic signed [lsf_pkg::CFG_W-1:0]  lo_s;
    logic signed [lsf_pkg::CFG_W-1:0]  hi_s;
    logic                              swap;
    logic [CMPW-1:0]                   idx_c;
    logic [CMPW-1:0]                   lo_c;
    logic [CMPW-1:0]                   hi_c;
    logic                              below_max;
    logic                              hit;
    logic signed [2*lsf_pkg::XW-1:0]   xx;
    logic signed [2*lsf_pkg::XW-1:0]   yy;
    logic signed [2*lsf_pkg::XW-1:0]   xy;
    logic [lsf_pkg::NW-1:0]            cnt_next;
    logic signed [lsf_pkg::SXW-1:0]    sx_next;
    logic signed [lsf_pkg::SXW-1:0]    sy_next;
    logic [lsf_pkg::SXXW-1:0]          sxx_next;
    logic [lsf_pkg::SXXW-1:0]          syy_next;
    logic signed [lsf_pkg::SXYW-1:0]   sxy_next;
    logic [IW-1:0]                     idx_next;

    always_comb
    begin
        swap      = win_first_reg > win_final_reg;
        lo_s      = swap ? win_final_reg : win_first_reg;
        hi_s      = swap ? win_first_reg : win_final_reg;
        idx_c     = CMPW'(idx_reg);
        lo_c      = lo_s[lsf_pkg::CFG_W-1] ? '0 : CMPW'(lo_s[lsf_pkg::CFG_W-2:0]);
        hi_c      = CMPW'(hi_s[lsf_pkg::CFG_W-2:0]);
        below_max = idx_reg < IW'(MAX_SAMPLES);
        hit       = below_max && (idx_c >= lo_c) &&
                    (hi_s[lsf_pkg::CFG_W-1] || (idx_c <= hi_c));
        xx        = x_value * x_value;
        yy        = y_value * y_value;
        xy        = x_value * y_value;
        idx_next  = below_max ? idx_reg + IW'(1) : idx_reg;
        cnt_next  = cnt_reg;
        sx_next   = sx_reg;
        sy_next   = sy_reg;
        sxx_next  = sxx_reg;
        syy_next  = syy_reg;
        sxy_next  = sxy_reg;
        if (hit)
        begin
            cnt_next = cnt_reg + lsf_pkg::NW'(1);
            sx_next  = sx_reg + lsf_pkg::SXW'(x_value);
            sy_next  = sy_reg + lsf_pkg::SXW'(y_value);
            sxx_next = sxx_reg + lsf_pkg::SXXW'($unsigned(xx));
            syy_next = syy_reg + lsf_pkg::SXXW'($unsigned(yy));
            sxy_next = sxy_reg + lsf_pkg::SXYW'(xy);
        end
    end

    assign push        = take && is_last;
    assign snap.n      = cnt_next;
    assign snap.sx     = sx_next;
    assign snap.sy     = sy_next;
    assign snap.sxx    = sxx_next;
    assign snap.syy    = syy_next;
    assign snap.sxy    = sxy_next;
    assign snap.single = (lo_s > 0) && (hi_s > 0) && (lo_s == hi_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_first_reg <= '1;
            win_final_reg <= '1;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            sxx_reg       <= '0;
            syy_reg       <= '0;
            sxy_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    lsf_pkg::CFG_WINDOW_FIRST: win_first_reg <= cfg_data;
                    default:                   win_final_reg <= cfg_data;
                endcase
            end
            if (take)
            begin
                if (is_last)
                begin
                    idx_reg <= '0;
                    cnt_reg <= '0;
                    sx_reg  <= '0;
                    sy_reg  <= '0;
                    sxx_reg <= '0;
                    syy_reg <= '0;
                    sxy_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_next;
                    cnt_reg <= cnt_next;
                    sx_reg  <= sx_next;
                    sy_reg  <= sy_next;
                    sxx_reg <= sxx_next;
                    syy_reg <= syy_next;
                    sxy_reg <= sxy_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/lsf_queue.sv
// Two-entry snapshot queue between the front end and the solver.
// Depends on lsf_pkg for the snapshot type.
`default_nettype none

module lsf_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire lsf_pkg::snap_t din,
    input  wire logic           pop,
    output lsf_pkg::snap_t      dout,
    output logic                empty,
    output logic                full
);

    lsf_pkg::snap_t ent_reg [2];
    logic           wr_reg;
    logic           rd_reg;
    logic [1:0]     cnt_reg;

    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'd2);
    assign dout  = ent_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue pop while empty");

endmodule

`default_nettype wire

>>> rtl/lsf_arith.sv
// Shared bit-serial unit: shift-add multiply, restoring divide, digit square root.
// Depends on lsf_pkg for operand width and operation codes.
`default_nettype none

module lsf_arith (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lsf_pkg::arith_req_t req,
    output lsf_pkg::arith_rsp_t      rsp
);

    localparam int W = lsf_pkg::W;

    logic                   active_reg;
    logic                   done_reg;
    lsf_pkg::op_t           op_reg;
    logic [lsf_pkg::CW-1:0] cnt_reg;
    lsf_pkg::word_t         acc_reg;
    lsf_pkg::word_t         x_reg;
    lsf_pkg::word_t         d_reg;
    logic [lsf_pkg::MW-1:0] y_reg;
    logic [W:0]             rem_reg;

    logic [W:0] div_rem2;
    logic       div_ge;
    logic [W:0] sq_rem2;
    logic [W:0] sq_trial;
    logic       sq_ge;

    always_comb
    begin
        div_rem2 = {rem_reg[W-1:0], x_reg[W-1]};
        div_ge   = div_rem2 >= {1'b0, d_reg};
        sq_rem2  = {rem_reg[W-2:0], x_reg[W-1:W-2]};
        sq_trial = {acc_reg[W-2:0], 2'b01};
        sq_ge    = sq_rem2 >= sq_trial;
    end

    assign rsp.busy = active_reg;
    assign rsp.done = done_reg;
    assign rsp.res  = (op_reg == lsf_pkg::OP_DIV) ? x_reg : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            op_reg     <= lsf_pkg::OP_MUL;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !active_reg)
            begin
                active_reg <= 1'b1;
                op_reg     <= req.op;
                unique case (req.op)
                    lsf_pkg::OP_MUL: cnt_reg <= lsf_pkg::CW'(lsf_pkg::MW);
                    lsf_pkg::OP_DIV: cnt_reg <= lsf_pkg::CW'(W);
                    default:         cnt_reg <= lsf_pkg::CW'(W / 2);
                endcase
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg - lsf_pkg::CW'(1);
                if (cnt_reg == lsf_pkg::CW'(1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !active_reg)
        begin
            acc_reg <= '0;
            rem_reg <= '0;
            x_reg   <= req.a;
            d_reg   <= req.b;
            y_reg   <= req.b[lsf_pkg::MW-1:0];
        end
        else if (active_reg)
        begin
            unique case (op_reg)
                lsf_pkg::OP_MUL:
                begin
                    if (y_reg[0])
                    begin
                        acc_reg <= acc_reg + x_reg;
                    end
                    x_reg <= x_reg << 1;
                    y_reg <= y_reg >> 1;
                end
                lsf_pkg::OP_DIV:
                begin
                    rem_reg <= div_ge ? div_rem2 - {1'b0, d_reg} : div_rem2;
                    x_reg   <= {x_reg[W-2:0], div_ge};
                end
                default:
                begin
                    rem_reg <= sq_ge ? sq_rem2 - sq_trial : sq_rem2;
                    acc_reg <= {acc_reg[W-2:0], sq_ge};
                    x_reg   <= x_reg << 2;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/lsf_back.sv
// Solver: sequences products, quotients and roots on the shared unit per data set.
// Depends on lsf_pkg and lsf_arith.
`default_nettype none

module lsf_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_empty,
    input  wire lsf_pkg::snap_t          q_data,
    output logic                         q_pop,
    output logic                         done,
    output logic signed [lsf_pkg::OW-1:0]    slope_q16,
    output logic signed [lsf_pkg::OW-1:0]    intercept_q16,
    output logic signed [lsf_pkg::CORRW-1:0] correlation_q16,
    output logic [lsf_pkg::OW-1:0]           slope_dev_q16,
    output logic [lsf_pkg::OW-1:0]           intercept_dev_q16,
    output logic [1:0]                       fit_status
);

    typedef enum logic [3:0] {
        BK_IDLE  = 4'b0001,
        BK_ISSUE = 4'b0010,
        BK_WAIT  = 4'b0100,
        BK_EMIT  = 4'b1000
    } bk_state_t;

    typedef enum logic [4:0] {
        ST_NSXX, ST_SXSX, ST_NSYY, ST_SYSY, ST_NSXY, ST_SXSY, ST_SYXX, ST_SXXY,
        ST_SLOPE, ST_ICPT, ST_CC, ST_XY2, ST_PXY, ST_CDIV, ST_CSQ, ST_D1,
        ST_SDIV, ST_SSQ, ST_NN, ST_RX, ST_IDIV, ST_ISQ
    } step_t;

    localparam int NW = lsf_pkg::NW;

    bk_state_t                       st_reg;
    bk_state_t                       st_next;
    step_t                           step_reg;
    step_t                           step_next;
    logic                            done_reg;
    lsf_pkg::snap_t                  snap_reg;
    logic [lsf_pkg::SXW-1:0]         sxm_reg;
    logic [lsf_pkg::SXW-1:0]         sym_reg;
    logic [lsf_pkg::SXYW-1:0]        sxym_reg;
    lsf_pkg::word_t                  t1_reg;
    lsf_pkg::word_t                  t2_reg;
    lsf_pkg::word_t                  cxx_reg;
    lsf_pkg::word_t                  cyy_reg;
    lsf_pkg::word_t                  cxy_reg;
    lsf_pkg::word_t                  ni_reg;
    lsf_pkg::word_t                  cc_reg;
    lsf_pkg::word_t                  xy2_reg;
    lsf_pkg::word_t                  r_reg;
    logic                            cxx_neg_reg;
    logic                            cxy_neg_reg;
    logic                            ni_neg_reg;
    logic [lsf_pkg::OW-1:0]          slope_reg;
    logic [lsf_pkg::OW-1:0]          icpt_reg;
    logic [lsf_pkg::CORRW-1:0]       corr_reg;
    logic [lsf_pkg::OW-1:0]          sdev_reg;
    logic [lsf_pkg::OW-1:0]          idev_reg;
    lsf_pkg::status_t                status_reg;

    lsf_pkg::arith_req_t             req;
    lsf_pkg::arith_rsp_t             rsp;
    logic                            cap;
    logic                            stop_early;
    logic [2*NW-1:0]                 nn;
    lsf_pkg::smag_t                  dif;
    lsf_pkg::word_t                  rnd;
    lsf_pkg::word_t                  lim48;

    lsf_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign cap        = (st_reg == BK_WAIT) && rsp.done;
    assign stop_early = snap_reg.single || cxx_neg_reg || (cxx_reg == '0) ||
                        (snap_reg.n < NW'(2));
    assign nn         = (2*NW)'(snap_reg.n) * (2*NW)'(snap_reg.n - NW'(1));
    assign q_pop      = (st_reg == BK_IDLE) && !q_empty;
    assign lim48      = lsf_pkg::word_t'({lsf_pkg::OW{1'b1}});

    always_comb
    begin
        req.start = (st_reg == BK_ISSUE);
        req.op    = lsf_pkg::OP_MUL;
        req.a     = '0;
        req.b     = '0;
        case (step_reg)
            ST_NSXX:  begin req.a = lsf_pkg::word_t'(snap_reg.sxx); req.b = lsf_pkg::word_t'(snap_reg.n); end
            ST_SXSX:  begin req.a = lsf_pkg::word_t'(sxm_reg); req.b = lsf_pkg::word_t'(sxm_reg); end
            ST_NSYY:  begin req.a = lsf_pkg::word_t'(snap_reg.syy); req.b = lsf_pkg::word_t'(snap_reg.n); end
            ST_SYSY:  begin req.a = lsf_pkg::word_t'(sym_reg); req.b = lsf_pkg::word_t'(sym_reg); end
            ST_NSXY:  begin req.a = lsf_pkg::word_t'(sxym_reg); req.b = lsf_pkg::word_t'(snap_reg.n); end
            ST_SXSY:  begin req.a = lsf_pkg::word_t'(sxm_reg); req.b = lsf_pkg::word_t'(sym_reg); end
            ST_SYXX:  begin req.a = lsf_pkg::word_t'(snap_reg.sxx); req.b = lsf_pkg::word_t'(sym_reg); end
            ST_SXXY:  begin req.a = lsf_pkg::word_t'(sxym_reg); req.b = lsf_pkg::word_t'(sxm_reg); end
            ST_SLOPE:
            begin
                req.op = lsf_pkg::OP_DIV;
                req.a  = (cxy_reg << 17) + cxx_reg;
                req.b  = cxx_reg << 1;
            end
            ST_ICPT:
            begin
                req.op = lsf_pkg::OP_DIV;
                req.a  = (ni_reg << 17) + cxx_reg;
                req.b  = cxx_reg << 1;
            end
            ST_CC:    begin req.a = cxx_reg; req.b = cxx_reg; end
            ST_XY2:   begin req.a = cxy_reg; req.b = cxy_reg; end
            ST_PXY:   begin req.a = cxx_reg; req.b = cyy_reg; end
            ST_CDIV:  begin req.op = lsf_pkg::OP_DIV; req.a = xy2_reg << 34; req.b = t1_reg; end
            ST_CSQ:   begin req.op = lsf_pkg::OP_SQRT; req.a = t1_reg; end
            ST_D1:    begin req.a = cc_reg; req.b = lsf_pkg::word_t'(snap_reg.n - NW'(1)); end
            ST_SDIV:  begin req.op = lsf_pkg::OP_DIV; req.a = r_reg << 34; req.b = t1_reg; end
            ST_SSQ:   begin req.op = lsf_pkg::OP_SQRT; req.a = t2_reg; end
            ST_NN:    begin req.a = cc_reg; req.b = lsf_pkg::word_t'(nn); end
            ST_RX:    begin req.a = r_reg; req.b = lsf_pkg::word_t'(snap_reg.sxx); end
            ST_IDIV:  begin req.op = lsf_pkg::OP_DIV; req.a = t2_reg << 34; req.b = t1_reg; end
            ST_ISQ:   begin req.op = lsf_pkg::OP_SQRT; req.a = t2_reg; end
            default:  begin req.a = '0; end
        endcase
    end

    always_comb
    begin
        st_next   = st_reg;
        step_next = step_reg;
        unique case (st_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    st_next   = BK_ISSUE;
                    step_next = ST_NSXX;
                end
            end
            BK_ISSUE:
            begin
                st_next = BK_WAIT;
            end
            BK_WAIT:
            begin
                if (rsp.done)
                begin
                    st_next   = BK_ISSUE;
                    step_next = step_t'(step_reg + 5'd1);
                    if (step_reg == ST_ISQ || (step_reg == ST_SXXY && stop_early))
                    begin
                        st_next = BK_EMIT;
                    end
                    else if (step_reg == ST_PXY && cyy_reg == '0)
                    begin
                        step_next = ST_D1;
                    end
                end
            end
            BK_EMIT:
            begin
                st_next = BK_IDLE;
            end
            default:
            begin
                st_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= BK_IDLE;
            step_reg <= ST_NSXX;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            step_reg <= step_next;
            done_reg <= (st_reg == BK_EMIT);
        end
    end

    always_comb
    begin
        dif = lsf_pkg::sdiff(t1_reg, 1'b0, rsp.res, 1'b0);
        case (step_reg)
            ST_SXSY: dif = lsf_pkg::sdiff(t1_reg, snap_reg.sxy[lsf_pkg::SXYW-1], rsp.res,
                                          snap_reg.sx[lsf_pkg::SXW-1] ^
                                          snap_reg.sy[lsf_pkg::SXW-1]);
            ST_SXXY: dif = lsf_pkg::sdiff(t1_reg, snap_reg.sy[lsf_pkg::SXW-1], rsp.res,
                                          snap_reg.sx[lsf_pkg::SXW-1] ^
                                          snap_reg.sxy[lsf_pkg::SXYW-1]);
            default: dif = lsf_pkg::sdiff(t1_reg, 1'b0, rsp.res, 1'b0);
        endcase
        rnd = lsf_pkg::rsat(rsp.res, (step_reg == ST_CSQ) ?
                            lsf_pkg::word_t'(65536) : lim48);
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            snap_reg   <= q_data;
            sxm_reg    <= q_data.sx[lsf_pkg::SXW-1] ? lsf_pkg::SXW'(-q_data.sx)
                                                    : lsf_pkg::SXW'(q_data.sx);
            sym_reg    <= q_data.sy[lsf_pkg::SXW-1] ? lsf_pkg::SXW'(-q_data.sy)
                                                    : lsf_pkg::SXW'(q_data.sy);
            sxym_reg   <= q_data.sxy[lsf_pkg::SXYW-1] ? lsf_pkg::SXYW'(-q_data.sxy)
                                                      : lsf_pkg::SXYW'(q_data.sxy);
            slope_reg  <= '0;
            icpt_reg   <= '0;
            corr_reg   <= '0;
            sdev_reg   <= '0;
            idev_reg   <= '0;
            status_reg <= lsf_pkg::FIT_OK;
        end
        else if (cap)
        begin
            case (step_reg)
                ST_NSXX, ST_NSYY, ST_NSXY, ST_SYXX, ST_CDIV, ST_D1, ST_NN:
                begin
                    t1_reg <= rsp.res;
                end
                ST_SDIV, ST_RX, ST_IDIV:
                begin
                    t2_reg <= rsp.res;
                end
                ST_SXSX:
                begin
                    cxx_reg     <= dif.mag;
                    cxx_neg_reg <= dif.neg;
                end
                ST_SYSY:
                begin
                    cyy_reg <= dif.neg ? '0 : dif.mag;
                end
                ST_SXSY:
                begin
                    cxy_reg     <= dif.mag;
                    cxy_neg_reg <= dif.neg;
                end
                ST_SXXY:
                begin
                    ni_reg     <= dif.mag;
                    ni_neg_reg <= dif.neg;
                    if (snap_reg.single)
                    begin
                        status_reg <= lsf_pkg::FIT_SINGLE;
                    end
                    else if (stop_early)
                    begin
                        status_reg <= lsf_pkg::FIT_XFLAT;
                    end
                end
                ST_SLOPE: slope_reg <= lsf_pkg::qsat(rsp.res, cxy_neg_reg);
                ST_ICPT:  icpt_reg  <= lsf_pkg::qsat(rsp.res, ni_neg_reg);
                ST_CC:    cc_reg    <= rsp.res;
                ST_XY2:   xy2_reg   <= rsp.res;
                ST_PXY:
                begin
                    // cxx*cyy is the divisor of the correlation step
                    t1_reg <= rsp.res;
                    r_reg  <= (rsp.res > xy2_reg) ? rsp.res - xy2_reg : '0;
                    if (cyy_reg == '0)
                    begin
                        status_reg <= lsf_pkg::FIT_YFLAT;
                    end
                end
                ST_CSQ:
                begin
                    corr_reg <= cxy_neg_reg ? -lsf_pkg::CORRW'(rnd) : lsf_pkg::CORRW'(rnd);
                end
                ST_SSQ:   sdev_reg <= rnd[lsf_pkg::OW-1:0];
                ST_ISQ:   idev_reg <= rnd[lsf_pkg::OW-1:0];
                default:  t1_reg   <= t1_reg;
            endcase
        end
    end

    assign done              = done_reg;
    assign slope_q16         = slope_reg;
    assign intercept_q16     = icpt_reg;
    assign correlation_q16   = corr_reg;
    assign slope_dev_q16     = sdev_reg;
    assign intercept_dev_q16 = idev_reg;
    assign fit_status        = status_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n) done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");
    a_xflat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == lsf_pkg::FIT_XFLAT || status_reg == lsf_pkg::FIT_SINGLE))
        |-> (slope_reg == '0 && icpt_reg == '0 && sdev_reg == '0 && idev_reg == '0))
        else $error("degenerate fit with nonzero result");
    a_rsp_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (st_reg == BK_WAIT))
        else $error("arith completion outside wait state");

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for least_squares_line_fit_top: streams sample pairs under several
// window settings and checks each fit result against a wide-integer predictor.
// Depends on lsf_pkg and the least_squares_line_fit_top RTL.
`default_nettype none

module testbench;

    typedef logic signed [255:0] wide_s;
    typedef logic [255:0]        wide_u;

    localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;
    localparam int QUIET_LIMIT = 50000;

    typedef struct {
        logic [47:0]      slope;
        logic [47:0]      icpt;
        logic [17:0]      corr;
        logic [47:0]      sdev;
        logic [47:0]      idev;
        lsf_pkg::status_t status;
    } fit_result_t;

    class fit_scoreboard;
        int errors;
        int fits_checked;
        int pairs_seen;
        int win_first;
        int win_final;
        int unsigned idx;
        int unsigned cnt;
        longint sx, sy, sxx, syy, sxy;
        fit_result_t fits_due[$];

        function new();
            win_first = -1;
            win_final = -1;
            clear_set();
        endfunction

        function void clear_set();
            idx = 0;
            cnt = 0;
            sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
        endfunction

        function void set_window(logic [0:0] index, logic signed [12:0] value);
            if (index == lsf_pkg::CFG_WINDOW_FIRST)
                win_first = int'(value);
            else
                win_final = int'(value);
        endfunction

        function wide_u isqrt(wide_u a);
            wide_u r;
            wide_u t;
            r = '0;
            for (int b = 127; b >= 0; b--)
            begin
                t = r | (wide_u'(1) << b);
                if (t * t <= a)
                    r = t;
            end
            return r;
        endfunction

        function logic [47:0] root_round(wide_u a, wide_u b, wide_u lim);
            wide_u v;
            v = isqrt(a / b);
            if (v >= lim)
                return lim[47:0];
            if ((a << 2) >= (2 * v + 1) * (2 * v + 1) * b)
                v = v + 1;
            if (v > lim)
                v = lim;
            return v[47:0];
        endfunction

        function logic [47:0] round_quot(wide_s num, wide_u den);
            wide_u m;
            wide_u q;
            wide_u lim;
            m = num < 0 ? wide_u'(-num) : wide_u'(num);
            q = ((m << 17) + den) / (den << 1);
            lim = num < 0 ? wide_u'(48'h8000_0000_0000) : wide_u'(48'h7FFF_FFFF_FFFF);
            if (q > lim)
                q = lim;
            return num < 0 ? -q[47:0] : q[47:0];
        endfunction

        function void note_pair(logic signed [15:0] x, logic signed [15:0] y, bit last);
            int f, l, lo, t;
            wide_s n, cxx, cyy, cxy, ni;
            wide_u cc, xy2, pxy, r, c;
            fit_result_t e;
            pairs_seen++;
            f = win_first;
            l = win_final;
            if (f > l)
            begin
                t = f; f = l; l = t;
            end
            lo = f < 0 ? 0 : f;
            if (idx < 4096)
            begin
                if (int'(idx) >= lo && (l < 0 || int'(idx) <= l))
                begin
                    cnt++;
                    sx += longint'(x);
                    sy += longint'(y);
                    sxx += longint'(x) * longint'(x);
                    syy += longint'(y) * longint'(y);
                    sxy += longint'(x) * longint'(y);
                end
                idx++;
            end
            if (!last)
                return;
            e = '{0, 0, 0, 0, 0, lsf_pkg::FIT_OK};
            n = wide_s'(cnt);
            cxx = n * wide_s'(sxx) - wide_s'(sx) * wide_s'(sx);
            cyy = n * wide_s'(syy) - wide_s'(sy) * wide_s'(sy);
            cxy = n * wide_s'(sxy) - wide_s'(sx) * wide_s'(sy);
            ni = wide_s'(sy) * wide_s'(sxx) - wide_s'(sx) * wide_s'(sxy);
            if (f > 0 && l > 0 && f == l)
                e.status = lsf_pkg::FIT_SINGLE;
            else if (cxx <= 0 || cnt < 2)
                e.status = lsf_pkg::FIT_XFLAT;
            else
            begin
                if (cyy < 0)
                    cyy = '0;
                cc = wide_u'(cxx * cxx);
                xy2 = wide_u'(cxy * cxy);
                pxy = '0;
                e.slope = round_quot(cxy, wide_u'(cxx));
                e.icpt = round_quot(ni, wide_u'(cxx));
                if (cyy == 0)
                    e.status = lsf_pkg::FIT_YFLAT;
                else
                begin
                    pxy = wide_u'(cxx * cyy);
                    c = wide_u'(root_round(xy2 << 32, pxy, wide_u'(65536)));
                    e.corr = cxy < 0 ? -c[17:0] : c[17:0];
                end
                r = pxy > xy2 ? pxy - xy2 : '0;
                e.sdev = root_round(r << 32, wide_u'(cnt - 1) * cc, wide_u'(SAT48));
                e.idev = root_round((r * wide_u'(sxx)) << 32,
                                    wide_u'(cnt) * wide_u'(cnt - 1) * cc, wide_u'(SAT48));
            end
            fits_due = {fits_due, e};
            clear_set();
        endfunction

        function void check(fit_result_t a);
            fit_result_t e;
            if (fits_due.size() == 0)
            begin
                $display("%0t: unexpected fit result, status %0d", $time, a.status);
                errors++;
                return;
            end
            e = fits_due.pop_front();
            fits_checked++;
            if (a.slope !== e.slope)
            begin
                $display("%0t: slope_q16 exp %h got %h", $time, e.slope, a.slope);
                errors++;
            end
            if (a.icpt !== e.icpt)
            begin
                $display("%0t: intercept_q16 exp %h got %h", $time, e.icpt, a.icpt);
                errors++;
            end
            if (a.corr !== e.corr)
            begin
                $display("%0t: correlation_q16 exp %h got %h", $time, e.corr, a.corr);
                errors++;
            end
            if (a.sdev !== e.sdev)
            begin
                $display("%0t: slope_dev_q16 exp %h got %h", $time, e.sdev, a.sdev);
                errors++;
            end
            if (a.idev !== e.idev)
            begin
                $display("%0t: intercept_dev_q16 exp %h got %h", $time, e.idev, a.idev);
                errors++;
            end
            if (a.status !== e.status)
            begin
                $display("%0t: fit_status exp %0d got %0d", $time, e.status, a.status);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] x_value = '0;
    logic signed [15:0] y_value = '0;
    logic is_last = 1'b0;
    logic cfg_we = 1'b0;
    logic [lsf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lsf_pkg::CFG_W-1:0] cfg_data = '0;
    logic done;
    logic signed [47:0] slope_q16;
    logic signed [47:0] intercept_q16;
    logic signed [17:0] correlation_q16;
    logic [47:0] slope_dev_q16;
    logic [47:0] intercept_dev_q16;
    logic [1:0] fit_status;

    fit_scoreboard sb = new();
    bit idle_on = 1'b1;
    int transfers = 0;
    int results_seen = 0;
    int seen_last = 0;
    int quiet = 0;
    int configs = 0;

    always #5 clk = ~clk;

    least_squares_line_fit_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .x_value(x_value), .y_value(y_value), .is_last(is_last),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .slope_q16(slope_q16), .intercept_q16(intercept_q16),
        .correlation_q16(correlation_q16), .slope_dev_q16(slope_dev_q16),
        .intercept_dev_q16(intercept_dev_q16), .fit_status(fit_status)
    );

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check('{slope_q16, intercept_q16, correlation_q16, slope_dev_q16,
                       intercept_dev_q16, lsf_pkg::status_t'(fit_status)});
            results_seen++;
        end
    end

    always @(negedge clk)
    begin
        if (transfers + results_seen != seen_last)
            quiet = 0;
        else
            quiet++;
        seen_last = transfers + results_seen;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("least_squares_line_fit_top test failed");
            $finish;
        end
    end

    task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y, bit last);
        bit taken;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        start <= 1'b1;
        x_value <= x;
        y_value <= y;
        is_last <= last;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        sb.note_pair(x, y, last);
        transfers++;
    endtask

    task automatic write_window(logic [0:0] index, logic signed [12:0] value);
        start <= 1'b0;
        wait (sb.fits_due.size() == 0);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_window(index, value);
        configs++;
    endtask

    task automatic send_set(int len);
        int mode;
        logic signed [15:0] x, y, cx, cy;
        mode = $urandom_range(0, 5);
        cx = 16'($urandom);
        cy = 16'($urandom);
        for (int i = 0; i < len; i++)
        begin
            x = 16'($urandom);
            y = 16'($urandom);
            case (mode)
                1:
                begin
                    x = 16'(int'($urandom_range(0, 40)) - 20);
                    y = 16'(int'($urandom_range(0, 40)) - 20);
                end
                2: x = cx;
                3: y = cy;
                4:
                begin
                    x = 16'(int'($urandom_range(0, 2000)) - 1000);
                    y = 16'(3 * int'(x) - 7);
                end
                5:
                begin
                    x = 16'(int'($urandom_range(0, 255)) - 128);
                    y = 16'(int'(cy) - int'(x));
                end
                default: ;
            endcase
            send_pair(x, y, i == len - 1);
        end
    endtask

    initial
    begin
        int f, l;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, flat x, flat y, lone pair
        send_pair(-16'sd32768, -16'sd32768, 1'b0);
        send_pair(16'sd32767, 16'sd32767, 1'b1);
        send_pair(16'sd32767, -16'sd32768, 1'b0);
        send_pair(-16'sd32768, 16'sd32767, 1'b0);
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(16'sd5, 16'sd1, 1'b0);
        send_pair(16'sd5, 16'sd2, 1'b0);
        send_pair(16'sd5, 16'sd3, 1'b1);
        send_pair(16'sd1, 16'sd7, 1'b0);
        send_pair(16'sd2, 16'sd7, 1'b0);
        send_pair(16'sd3, 16'sd7, 1'b1);
        send_pair(16'sd9, 16'sd9, 1'b1);
        write_window(lsf_pkg::CFG_WINDOW_FIRST, 13'sd3);
        write_window(lsf_pkg::CFG_WINDOW_FINAL, 13'sd3);
        send_set(5);
        write_window(lsf_pkg::CFG_WINDOW_FIRST, 13'sd100);
        write_window(lsf_pkg::CFG_WINDOW_FINAL, 13'sd200);
        send_set(4);
        write_window(lsf_pkg::CFG_WINDOW_FIRST, 13'sd5);
        write_window(lsf_pkg::CFG_WINDOW_FINAL, 13'sd1);
        send_set(8);

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph)
                0: begin f = -1; l = -1; end
                1: begin f = 0; l = 4095; end
                2: begin f = 4095; l = -1; end
                3: begin f = 0; l = 0; end
                4: begin f = 4095; l = 4095; end
                5: begin f = 2; l = 6; end
                6: begin f = -1; l = 3; end
                7: begin f = 4; l = -1; end
                8: begin f = $urandom_range(0, 4096) - 1; l = $urandom_range(0, 4096) - 1; end
                default: begin f = $urandom_range(0, 13) - 1; l = $urandom_range(0, 13) - 1; end
            endcase
            if (ph >= 9)
                idle_on = 1'b0;
            write_window(lsf_pkg::CFG_WINDOW_FIRST, 13'(f));
            write_window(lsf_pkg::CFG_WINDOW_FINAL, 13'(l));
            for (int k = 0; k < 7; k++)
                send_set($urandom_range(1, 14));
        end
        start <= 1'b0;

        wait (sb.fits_due.size() == 0);
        repeat (3000) @(posedge clk);
        $display("Covered %0d pairs, %0d fits checked, %0d window writes.",
                 sb.pairs_seen, sb.fits_checked, configs);
        if (sb.errors == 0 && sb.fits_due.size() == 0)
            $display("least_squares_line_fit_top test passed");
        else
            $display("least_squares_line_fit_top test failed");
        $finish;
    end

endmodule

`default_nettype wire
